FILE: hdl/spdq_pkg.sv
// ----------------------------------------------------------------------------
// spdq_pkg
// Shared types, constants and helpers for the slot pool with data queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spdq_pkg;

   localparam int SLOTS    = 16;
   localparam int RING_LEN = SLOTS + 1;
   localparam int PTR_W    = $clog2(RING_LEN);
   localparam int SLOT_W   = 4;
   localparam int CNT_W    = 5;
   localparam int OP_W     = 2;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PUSH    = 2'd2,
      OP_POP     = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_RESP
   } state_type;

   // controller -> datapath commands
   typedef struct packed {
      logic load;   // capture the incoming request
      logic exec;   // run the captured operation
   } dp_cmd_type;

   // advance a ring pointer with wrap at RING_LEN
   function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] n;
      if (p == PTR_W'(RING_LEN - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/spdq_ctrl.sv
// ----------------------------------------------------------------------------
// spdq_ctrl
// Request sequencer: accept, execute, then hold the response until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module spdq_ctrl
   import spdq_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output dp_cmd_type      cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
         end
         ST_RESP: begin
            rsp_tvalid = 1'b1;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hdl/spdq_dpath.sv
// ----------------------------------------------------------------------------
// spdq_dpath
// Free ring, data ring, pointers and the response registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spdq_dpath
   import spdq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire dp_cmd_type        cmd,
   input  wire logic [OP_W-1:0]   opcode,
   input  wire logic [SLOT_W-1:0] slot_in,
   output logic                   status,
   output logic [SLOT_W-1:0]      slot_out,
   output logic [CNT_W-1:0]       queued_count
);

   logic [SLOT_W-1:0] free_ring_ff [RING_LEN];
   logic [SLOT_W-1:0] data_ring_ff [RING_LEN];

   op_type            op_ff;
   logic [SLOT_W-1:0] slot_ff;

   logic [PTR_W-1:0]  free_head_ff, free_tail_ff;
   logic [PTR_W-1:0]  data_head_ff, data_tail_ff;
   logic [CNT_W-1:0]  data_count_ff, data_count_in;

   logic [SLOT_W-1:0] free_rd_ff, data_rd_ff;
   logic              status_ff, take_ff, sel_data_ff;

   logic free_empty, free_full, data_empty, data_full, fail;

   // request capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= op_type'(opcode);
         slot_ff <= slot_in;
      end
   end

   assign free_empty = (free_head_ff == free_tail_ff);
   assign free_full  = (ring_next(free_tail_ff) == free_head_ff);
   assign data_empty = (data_head_ff == data_tail_ff);
   assign data_full  = (ring_next(data_tail_ff) == data_head_ff);

   always_comb begin
      fail          = 1'b0;
      data_count_in = data_count_ff;
      case (op_ff)
         OP_ALLOC:   fail = free_empty;
         OP_RELEASE: fail = free_full;
         OP_PUSH: begin
            fail = data_full;
            if (!data_full) data_count_in = data_count_ff + 1'b1;
         end
         default: begin
            fail = data_empty;
            if (!data_empty) data_count_in = data_count_ff - 1'b1;
         end
      endcase
   end

   // pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= '0;
         free_tail_ff  <= PTR_W'(SLOTS);
         data_head_ff  <= '0;
         data_tail_ff  <= '0;
         data_count_ff <= '0;
      end else if (cmd.exec && !fail) begin
         data_count_ff <= data_count_in;
         case (op_ff)
            OP_ALLOC:   free_head_ff <= ring_next(free_head_ff);
            OP_RELEASE: free_tail_ff <= ring_next(free_tail_ff);
            OP_PUSH:    data_tail_ff <= ring_next(data_tail_ff);
            default:    data_head_ff <= ring_next(data_head_ff);
         endcase
      end
   end

   // free ring: entry i holds i (truncated to SLOT_W bits) after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RING_LEN; i++) begin
            free_ring_ff[i] <= SLOT_W'(i);
         end
      end else if (cmd.exec && !fail && op_ff == OP_RELEASE) begin
         free_ring_ff[free_tail_ff] <= slot_ff;
      end
   end

   // data ring: no reset, only entries between head and tail reach slot_out
   always_ff @(posedge clock) begin
      if (cmd.exec && !fail && op_ff == OP_PUSH) begin
         data_ring_ff[data_tail_ff] <= slot_ff;
      end
   end

   // registered reads and response
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         free_rd_ff   <= free_ring_ff[free_head_ff];
         data_rd_ff   <= data_ring_ff[data_head_ff];
         status_ff    <= fail;
         take_ff      <= !fail && (op_ff == OP_ALLOC || op_ff == OP_POP);
         sel_data_ff  <= (op_ff == OP_POP);
      end
   end

   assign status       = status_ff;
   assign slot_out     = take_ff ? (sel_data_ff ? data_rd_ff : free_rd_ff) : '0;
   assign queued_count = data_count_ff;

endmodule

`default_nettype wire

FILE: hdl/slot_pool_with_data_queue.sv
// Sequence: the accepting edge moves the sequencer to EXEC, which updates the rings and
//   loads the response registers; RESP then holds the response valid until taken.
// Flow: the sequencer holds one request at a time and waits for the response to be
//   taken before accepting the next.
// Reset: synchronous, active high; free ring reloaded with slots 0..SLOTS-1,
//   data ring empty, queued count zero. No clearing pass; ready right after reset.
// ----------------------------------------------------------------------------
// slot_pool_with_data_queue
// Buffer slot manager: a free ring of slot indices and a data queue ring.
// ----------------------------------------------------------------------------
`default_nettype none

module slot_pool_with_data_queue
   import spdq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [1:0] opcode, [5:2] slot_in, [7:6] zero
   // response channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [0] status, [4:1] slot_out,
                                         // [9:5] queued_count, [15:10] zero
);

   dp_cmd_type        cmd;
   logic              status;
   logic [SLOT_W-1:0] slot_out;
   logic [CNT_W-1:0]  queued_count;

   // sequencer: IDLE takes a request, EXEC updates rings, RESP holds result
   spdq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // rings, pointers, data count and response registers
   spdq_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .opcode       (req_tdata[1:0]),
      .slot_in      (req_tdata[5:2]),
      .status       (status),
      .slot_out     (slot_out),
      .queued_count (queued_count)
   );

   // high response bits are zero padding
   assign rsp_tdata = {6'd0, queued_count, slot_out, status};

endmodule

`default_nettype wire

FILE: tb/sv/tb_slot_pool_with_data_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_slot_pool_with_data_queue
// Self-checking bench for the slot pool: a ledger class mirrors both slot
// rings and predicts status, slot and queue depth for every accepted request;
// responses are compared in order while both channels idle at random.
// ----------------------------------------------------------------------------

import spdq_pkg::*;

typedef struct packed {
   logic              status;
   logic [SLOT_W-1:0] slot_out;
   logic [CNT_W-1:0]  queued_count;
} slot_rsp_type;

class slot_ledger;
   logic [SLOT_W-1:0] free_slots [RING_LEN];
   logic [SLOT_W-1:0] data_slots [RING_LEN];
   logic [PTR_W-1:0]  free_rd, free_wr, data_rd, data_wr;
   logic [CNT_W-1:0]  queued;
   slot_rsp_type      pending_rsp [$];
   int                errors;

   function new();
      for (int i = 0; i < RING_LEN; i++) begin
         free_slots[i] = SLOT_W'(i);
         data_slots[i] = '0;
      end
      free_rd = '0;
      free_wr = PTR_W'(SLOTS);
      data_rd = '0;
      data_wr = '0;
      queued  = '0;
      errors  = 0;
   endfunction

   function logic [PTR_W-1:0] wrap_inc(logic [PTR_W-1:0] p);
      return PTR_W'((int'(p) + 1) % RING_LEN);
   endfunction

   // apply one accepted request to the mirror and queue its response
   function void record_request(op_type op, logic [SLOT_W-1:0] slot);
      slot_rsp_type     r;
      logic [PTR_W-1:0] nxt;
      r = '0;
      case (op)
         OP_ALLOC: begin
            if (free_rd == free_wr) begin
               r.status = 1'b1;
            end else begin
               r.slot_out = free_slots[free_rd];
               free_rd    = wrap_inc(free_rd);
            end
         end
         OP_RELEASE: begin
            nxt = wrap_inc(free_wr);
            if (nxt == free_rd) begin
               r.status = 1'b1;
            end else begin
               free_slots[free_wr] = slot;
               free_wr             = nxt;
            end
         end
         OP_PUSH: begin
            nxt = wrap_inc(data_wr);
            if (nxt == data_rd) begin
               r.status = 1'b1;
            end else begin
               data_slots[data_wr] = slot;
               data_wr             = nxt;
               queued              = queued + 1'b1;
            end
         end
         default: begin
            if (data_rd == data_wr) begin
               r.status = 1'b1;
            end else begin
               r.slot_out = data_slots[data_rd];
               data_rd    = wrap_inc(data_rd);
               if (queued != 0) queued = queued - 1'b1;
            end
         end
      endcase
      r.queued_count = queued;
      pending_rsp.push_back(r);
   endfunction

   function void compare_response(logic [15:0] tdata);
      slot_rsp_type want;
      if (pending_rsp.size() == 0) begin
         $error("response 0x%04h arrived with no request outstanding", tdata);
         errors++;
         return;
      end
      want = pending_rsp.pop_front();
      if (tdata[0] !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, tdata[0]);
         errors++;
      end
      if (tdata[4:1] !== want.slot_out) begin
         $error("slot_out: expected %0d, got %0d", want.slot_out, tdata[4:1]);
         errors++;
      end
      if (tdata[9:5] !== want.queued_count) begin
         $error("queued_count: expected %0d, got %0d", want.queued_count, tdata[9:5]);
         errors++;
      end
   endfunction

   function int outstanding();
      return pending_rsp.size();
   endfunction
endclass

module tb_slot_pool_with_data_queue;

   localparam int RANDOM_REQUESTS = 700;
   localparam int IDLE_PCT        = 29;
   localparam int STALL_LIMIT     = 2000;  // cycles with no handshake on either side
   localparam int DRAIN_CYCLES    = 8;     // extra wait after the last response, to catch stray ones

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [1:0] opcode, [5:2] slot_in, [7:6] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [0] status, [4:1] slot_out, [9:5] queued_count,
                             // [15:10] zero

   slot_ledger ledger;
   bit         calm;         // when set, neither side idles
   int         quiet_cycles;

   slot_pool_with_data_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Present one request, optionally after a short random gap, and hold it
   // until the block takes it. The ledger is updated at the accepting edge.
   // With no gap, tvalid stays high: only one NBA per signal per step.
   task automatic send_request(input op_type op, input logic [SLOT_W-1:0] slot);
      int gap;
      if (!calm && $urandom_range(99) < IDLE_PCT) begin
         gap = $urandom_range(4, 1);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, slot, op};
      do @(posedge clock); while (!req_tready);
      ledger.record_request(op, slot);
   endtask

   // Response side: sample the handshake with the values from before the
   // edge, then pick the next tready.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ledger.compare_response(rsp_tdata);
      rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
   end

   // Watchdog: a long run of cycles with no handshake means the block hung.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int     sent;
      int     run;
      op_type op;

      clock        = 1'b0;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      calm         = 1'b0;
      ledger       = new();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // --- directed part ---
      // free ring starts full, data ring empty
      send_request(OP_RELEASE, 4'd15);  // release into full free ring fails
      send_request(OP_POP,     4'd9);   // pop from empty data ring fails
      send_request(OP_ALLOC,   4'd5);   // takes slot 0, slot_in ignored
      send_request(OP_RELEASE, 4'd15);  // slot 15 handed back a second time
      send_request(OP_PUSH,    4'd15);
      send_request(OP_PUSH,    4'd0);
      send_request(OP_POP,     4'd0);
      send_request(OP_POP,     4'd15);
      send_request(OP_POP,     4'd0);   // empty again
      // drain the free ring; the last allocate finds it empty
      for (int i = 0; i <= SLOTS; i++) send_request(OP_ALLOC, SLOT_W'(i));

      // --- random part ---
      // opening burst overfills the data ring so the full case is hit early
      for (int i = 0; i < SLOTS + 2; i++) send_request(OP_PUSH, SLOT_W'($urandom_range(15)));
      sent = SLOTS + 2;
      // Runs of one operation walk the rings to full and empty; short runs
      // mix the operations. A middle stretch runs with no idling at all.
      while (sent < RANDOM_REQUESTS) begin
         op  = op_type'($urandom_range(3));
         run = ($urandom_range(1) != 0) ? $urandom_range(4, 1) : $urandom_range(20, 5);
         for (int i = 0; i < run; i++) begin
            calm = (sent >= 300 && sent < 420);
            send_request(op, SLOT_W'($urandom_range(15)));
            sent++;
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // wait for every response, then a little longer for stray ones
      while (ledger.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/spdq_pkg.sv
hdl/spdq_ctrl.sv
hdl/spdq_dpath.sv
hdl/slot_pool_with_data_queue.sv
tb/sv/tb_slot_pool_with_data_queue.sv
